@@ hw/rtl/resp_reply_stream_parser_core_assert.svh @@
// Assertion helpers for the reply parser; expect clk and rst_n in scope.
`ifndef RESP_REPLY_STREAM_PARSER_CORE_ASSERT_SVH
`define RESP_REPLY_STREAM_PARSER_CORE_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define RRSP_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define RRSP_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hw/rtl/rrsp_pkg.sv @@
package rrsp_pkg;

    localparam int LENGTH_BITS_DEF = 32;

    localparam int BYTE_W   = 8;
    localparam int KIND_W   = 3;
    localparam int NUMBER_W = 64;
    localparam int CFG_IDX_W = 3;

    typedef logic [BYTE_W-1:0]          byte_t;
    typedef logic [KIND_W-1:0]          kind_t;
    typedef logic signed [NUMBER_W-1:0] number_t;
    typedef logic [CFG_IDX_W-1:0]       cfg_idx_t;

    localparam kind_t KIND_SIMPLE  = 3'd0;
    localparam kind_t KIND_ERROR   = 3'd1;
    localparam kind_t KIND_INTEGER = 3'd2;
    localparam kind_t KIND_BULK    = 3'd3;
    localparam kind_t KIND_ARRAY   = 3'd4;
    localparam kind_t KIND_UNKNOWN = 3'd5;

    localparam cfg_idx_t CFG_SIMPLE_MARKER  = 3'd0;
    localparam cfg_idx_t CFG_ERROR_MARKER   = 3'd1;
    localparam cfg_idx_t CFG_INTEGER_MARKER = 3'd2;
    localparam cfg_idx_t CFG_BULK_MARKER    = 3'd3;
    localparam cfg_idx_t CFG_ARRAY_MARKER   = 3'd4;
    localparam cfg_idx_t CFG_TERMINATOR     = 3'd5;

    localparam byte_t RST_SIMPLE_MARKER  = 8'd43;
    localparam byte_t RST_ERROR_MARKER   = 8'd45;
    localparam byte_t RST_INTEGER_MARKER = 8'd58;
    localparam byte_t RST_BULK_MARKER    = 8'd36;
    localparam byte_t RST_ARRAY_MARKER   = 8'd42;
    localparam byte_t RST_TERMINATOR     = 8'd13;

    localparam byte_t CH_ZERO  = 8'd48;
    localparam byte_t CH_NINE  = 8'd57;
    localparam byte_t CH_MINUS = 8'd45;

endpackage

@@ hw/rtl/rrsp_if.sv @@
interface rrsp_in_if;
    import rrsp_pkg::*;

    logic  valid;
    logic  ready;
    byte_t in_byte;

    modport source (output valid, output in_byte, input ready);
    modport sink (input valid, input in_byte, output ready);
endinterface

interface rrsp_out_if;
    import rrsp_pkg::*;

    logic    valid;
    logic    ready;
    kind_t   msg_kind;
    byte_t   payload_byte;
    logic    has_byte;
    number_t number_value;
    logic    end_of_message;

    modport source (output valid, output msg_kind, output payload_byte, output has_byte,
                    output number_value, output end_of_message, input ready);
    modport sink (input valid, input msg_kind, input payload_byte, input has_byte,
                  input number_value, input end_of_message, output ready);
endinterface

@@ hw/rtl/resp_reply_stream_parser_core.sv @@
// Latency: a result appears in the output register in the cycle after its byte is accepted.
// Throughput: one byte per cycle while no untaken result blocks; one parser pass per byte.
// The output register frees itself in the cycle its result is taken, so input keeps flowing.
// Reset: rst_n (async, active low) returns the parser to the marker wait, clears the
//   output valid and loads the default marker and terminator bytes.
module resp_reply_stream_parser_core #(
    parameter int LENGTH_BITS = rrsp_pkg::LENGTH_BITS_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  rrsp_pkg::cfg_idx_t cfg_index,
    input  rrsp_pkg::byte_t    cfg_data,
    rrsp_in_if.sink            bytes,
    rrsp_out_if.source         replies
);
    import rrsp_pkg::*;

    localparam logic [2:0] PH_IDLE      = 3'd0;
    localparam logic [2:0] PH_STRING    = 3'd1;
    localparam logic [2:0] PH_INT_FIRST = 3'd2;
    localparam logic [2:0] PH_INT       = 3'd3;
    localparam logic [2:0] PH_LENGTH    = 3'd4;
    localparam logic [2:0] PH_PRE       = 3'd5;
    localparam logic [2:0] PH_PAYLOAD   = 3'd6;
    localparam logic [2:0] PH_SKIP      = 3'd7;

    localparam logic [LENGTH_BITS-1:0] LEN_MAX = {LENGTH_BITS{1'b1}};

    byte_t simple_marker_reg, error_marker_reg, integer_marker_reg;
    byte_t bulk_marker_reg, array_marker_reg, terminator_reg;

    logic [2:0]             phase_reg, phase_next;
    kind_t                  kind_reg, kind_next;
    logic [NUMBER_W-1:0]    acc_reg, acc_next;
    logic                   minus_reg, minus_next;
    logic [LENGTH_BITS-1:0] rem_reg, rem_next;
    logic [1:0]             skip_reg, skip_next;

    logic    out_valid_reg;
    kind_t   out_kind_reg;
    byte_t   out_byte_reg;
    logic    out_has_reg;
    number_t out_num_reg;
    logic    out_end_reg;

    logic    emit;
    kind_t   e_kind;
    byte_t   e_byte;
    logic    e_has;
    number_t e_num;
    logic    e_end;

    byte_t                  b;
    logic                   accept;
    logic                   is_digit;
    logic                   is_term;
    logic [NUMBER_W-1:0]    int_wide;
    logic [LENGTH_BITS-1:0] acc_lo;
    logic [LENGTH_BITS+3:0] len_wide;
    logic [LENGTH_BITS-1:0] rem_dec;

    assign b       = bytes.in_byte;
    assign bytes.ready = !out_valid_reg || replies.ready;
    assign accept  = bytes.valid && bytes.ready;

    assign replies.valid          = out_valid_reg;
    assign replies.msg_kind       = out_kind_reg;
    assign replies.payload_byte   = out_byte_reg;
    assign replies.has_byte       = out_has_reg;
    assign replies.number_value   = out_num_reg;
    assign replies.end_of_message = out_end_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            simple_marker_reg  <= RST_SIMPLE_MARKER;
            error_marker_reg   <= RST_ERROR_MARKER;
            integer_marker_reg <= RST_INTEGER_MARKER;
            bulk_marker_reg    <= RST_BULK_MARKER;
            array_marker_reg   <= RST_ARRAY_MARKER;
            terminator_reg     <= RST_TERMINATOR;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_SIMPLE_MARKER:  simple_marker_reg  <= cfg_data;
                CFG_ERROR_MARKER:   error_marker_reg   <= cfg_data;
                CFG_INTEGER_MARKER: integer_marker_reg <= cfg_data;
                CFG_BULK_MARKER:    bulk_marker_reg    <= cfg_data;
                CFG_ARRAY_MARKER:   array_marker_reg   <= cfg_data;
                CFG_TERMINATOR:     terminator_reg     <= cfg_data;
                default:            ;
            endcase
        end
    end

    assign is_digit = b inside {[CH_ZERO:CH_NINE]};
    assign is_term  = (b == terminator_reg);
    // Integer path wraps mod 2^64; non-digits still add (byte - '0').
    assign int_wide = (acc_reg << 3) + (acc_reg << 1)
                    + {{(NUMBER_W-BYTE_W){1'b0}}, b} - NUMBER_W'(CH_ZERO);
    assign acc_lo   = acc_reg[LENGTH_BITS-1:0];
    assign len_wide = ({4'b0000, acc_lo} << 3) + ({4'b0000, acc_lo} << 1)
                    + (LENGTH_BITS+4)'(b - CH_ZERO);
    assign rem_dec  = rem_reg - LENGTH_BITS'(1);

    always_comb
    begin
        phase_next = phase_reg;
        kind_next  = kind_reg;
        acc_next   = acc_reg;
        minus_next = minus_reg;
        rem_next   = rem_reg;
        skip_next  = skip_reg;
        emit       = 1'b0;
        e_kind     = kind_reg;
        e_byte     = '0;
        e_has      = 1'b0;
        e_num      = '0;
        e_end      = 1'b0;

        case (phase_reg)
            PH_IDLE:
            begin
                acc_next   = '0;
                minus_next = 1'b0;
                rem_next   = '0;
                skip_next  = '0;
                if (b == simple_marker_reg)
                begin
                    kind_next  = KIND_SIMPLE;
                    phase_next = PH_STRING;
                end
                else if (b == error_marker_reg)
                begin
                    kind_next  = KIND_ERROR;
                    phase_next = PH_STRING;
                end
                else if (b == integer_marker_reg)
                begin
                    kind_next  = KIND_INTEGER;
                    phase_next = PH_INT_FIRST;
                end
                else if (b == bulk_marker_reg)
                begin
                    kind_next  = KIND_BULK;
                    phase_next = PH_LENGTH;
                end
                else if (b == array_marker_reg)
                begin
                    kind_next  = KIND_ARRAY;
                    phase_next = PH_LENGTH;
                end
                else
                begin
                    kind_next = KIND_UNKNOWN;
                    emit      = 1'b1;
                    e_kind    = KIND_UNKNOWN;
                    e_end     = 1'b1;
                end
            end
            PH_STRING:
            begin
                if (is_term)
                begin
                    phase_next = PH_SKIP;
                    skip_next  = 2'd1;
                end
                else
                begin
                    emit   = 1'b1;
                    e_byte = b;
                    e_has  = 1'b1;
                end
            end
            PH_INT_FIRST, PH_INT:
            begin
                if (is_term)
                begin
                    if (minus_reg)
                    begin
                        acc_next = '0 - acc_reg;
                    end
                    phase_next = PH_SKIP;
                    skip_next  = 2'd1;
                end
                else
                begin
                    if (phase_reg == PH_INT_FIRST && b == CH_MINUS)
                    begin
                        minus_next = 1'b1;
                    end
                    else
                    begin
                        acc_next = int_wide;
                    end
                    phase_next = PH_INT;
                end
            end
            PH_LENGTH:
            begin
                if (is_digit)
                begin
                    // Saturate at the length limit
                    if (len_wide > {4'b0000, LEN_MAX})
                    begin
                        acc_next = NUMBER_W'(LEN_MAX);
                    end
                    else
                    begin
                        acc_next = NUMBER_W'(len_wide);
                    end
                end
                else
                begin
                    phase_next = PH_PRE;
                end
            end
            PH_PRE:
            begin
                if (kind_reg == KIND_BULK)
                begin
                    rem_next = acc_lo;
                    if (acc_lo == '0)
                    begin
                        phase_next = PH_SKIP;
                        skip_next  = 2'd2;
                    end
                    else
                    begin
                        phase_next = PH_PAYLOAD;
                    end
                end
                else
                begin
                    phase_next = PH_IDLE;
                    emit       = 1'b1;
                    e_num      = acc_reg;
                    e_end      = 1'b1;
                end
            end
            PH_PAYLOAD:
            begin
                rem_next = rem_dec;
                if (rem_dec == '0)
                begin
                    phase_next = PH_SKIP;
                    skip_next  = 2'd2;
                end
                emit   = 1'b1;
                e_byte = b;
                e_has  = 1'b1;
            end
            default:
            begin
                if (skip_reg > 2'd1)
                begin
                    skip_next = skip_reg - 2'd1;
                end
                else
                begin
                    skip_next  = '0;
                    phase_next = PH_IDLE;
                    emit       = 1'b1;
                    e_end      = 1'b1;
                    if (kind_reg != KIND_SIMPLE && kind_reg != KIND_ERROR)
                    begin
                        e_num = acc_reg;
                    end
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE;
            kind_reg  <= KIND_SIMPLE;
            acc_reg   <= '0;
            minus_reg <= 1'b0;
            rem_reg   <= '0;
            skip_reg  <= '0;
        end
        else if (accept)
        begin
            phase_reg <= phase_next;
            kind_reg  <= kind_next;
            acc_reg   <= acc_next;
            minus_reg <= minus_next;
            rem_reg   <= rem_next;
            skip_reg  <= skip_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (accept && emit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (replies.ready)
        begin
            // drop the transaction once taken
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && emit)
        begin
            out_kind_reg <= e_kind;
            out_byte_reg <= e_byte;
            out_has_reg  <= e_has;
            out_num_reg  <= e_num;
            out_end_reg  <= e_end;
        end
    end

`include "resp_reply_stream_parser_core_assert.svh"

    `RRSP_ASSERT_NOW(a_byte_not_end, out_valid_reg && out_has_reg, !out_end_reg && out_num_reg == '0, "payload byte result marked as end or carries a number")
    `RRSP_ASSERT_NOW(a_unknown_single, out_valid_reg && out_kind_reg == KIND_UNKNOWN, out_end_reg && !out_has_reg, "unknown marker result is not a lone end result")
    `RRSP_ASSERT_NOW(a_payload_count, phase_reg == PH_PAYLOAD, rem_reg != '0, "payload phase with zero bytes remaining")
    `RRSP_ASSERT_NEXT(a_skip_count, accept && phase_next == PH_SKIP, skip_reg != 2'd0, "skip phase entered without a skip count")

endmodule

@@ bench/rrsp_reply_checker.sv @@
`timescale 1ns / 100ps

module rrsp_reply_checker #(
    parameter int LENGTH_BITS = rrsp_pkg::LENGTH_BITS_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  rrsp_pkg::cfg_idx_t cfg_index,
    input  rrsp_pkg::byte_t    cfg_data,
    rrsp_in_if                 byte_stream,
    rrsp_out_if                reply_stream,
    output int                 errors,
    output int                 pending
);
    import rrsp_pkg::*;

    typedef enum logic [2:0] {
        P_IDLE,
        P_STRING,
        P_INT_FIRST,
        P_INT,
        P_LENGTH,
        P_PRE,
        P_PAYLOAD,
        P_SKIP
    } phase_e;

    typedef struct packed {
        kind_t   kind;
        byte_t   payload;
        logic    has_byte;
        number_t number;
        logic    eom;
    } reply_t;

    reply_t expected_replies [$];
    int     err_count = 0;

    byte_t       markers [0:5];
    phase_e      phase;
    kind_t       cur_kind;
    logic [63:0] acc;
    logic        minus;
    logic [31:0] remaining;
    logic [1:0]  skip;

    // Advance the parser by one byte; returns 1 when the byte yields a reply.
    function automatic bit parse_byte(input byte_t b, output reply_t r);
        logic [63:0] d;
        logic [63:0] len_max;
        bit          is_digit;
        r        = '0;
        is_digit = (b >= CH_ZERO) && (b <= CH_NINE);
        d        = 64'(b) - 64'(CH_ZERO);
        len_max  = (64'd1 << LENGTH_BITS) - 64'd1;
        case (phase)
            P_IDLE:
            begin
                acc       = '0;
                minus     = 1'b0;
                remaining = '0;
                skip      = '0;
                if (b == markers[CFG_SIMPLE_MARKER])
                begin
                    cur_kind = KIND_SIMPLE;
                    phase    = P_STRING;
                end
                else if (b == markers[CFG_ERROR_MARKER])
                begin
                    cur_kind = KIND_ERROR;
                    phase    = P_STRING;
                end
                else if (b == markers[CFG_INTEGER_MARKER])
                begin
                    cur_kind = KIND_INTEGER;
                    phase    = P_INT_FIRST;
                end
                else if (b == markers[CFG_BULK_MARKER])
                begin
                    cur_kind = KIND_BULK;
                    phase    = P_LENGTH;
                end
                else if (b == markers[CFG_ARRAY_MARKER])
                begin
                    cur_kind = KIND_ARRAY;
                    phase    = P_LENGTH;
                end
                else
                begin
                    cur_kind = KIND_UNKNOWN;
                    r.kind   = KIND_UNKNOWN;
                    r.eom    = 1'b1;
                    return 1'b1;
                end
                return 1'b0;
            end
            P_STRING:
            begin
                if (b == markers[CFG_TERMINATOR])
                begin
                    phase = P_SKIP;
                    skip  = 2'd1;
                    return 1'b0;
                end
                r.kind     = cur_kind;
                r.payload  = b;
                r.has_byte = 1'b1;
                return 1'b1;
            end
            P_INT_FIRST, P_INT:
            begin
                if (b == markers[CFG_TERMINATOR])
                begin
                    if (minus)
                        acc = 64'd0 - acc;
                    phase = P_SKIP;
                    skip  = 2'd1;
                    return 1'b0;
                end
                // a minus counts as a sign only right after the marker
                if (phase == P_INT_FIRST && b == CH_MINUS)
                    minus = 1'b1;
                else
                    acc = acc * 64'd10 + d;
                phase = P_INT;
                return 1'b0;
            end
            P_LENGTH:
            begin
                if (is_digit)
                begin
                    if (acc > (len_max - d) / 64'd10)
                        acc = len_max;
                    else
                        acc = acc * 64'd10 + d;
                    return 1'b0;
                end
                phase = P_PRE;
                return 1'b0;
            end
            P_PRE:
            begin
                if (cur_kind == KIND_BULK)
                begin
                    remaining = acc[31:0];
                    if (remaining == '0)
                    begin
                        phase = P_SKIP;
                        skip  = 2'd2;
                    end
                    else
                        phase = P_PAYLOAD;
                    return 1'b0;
                end
                phase    = P_IDLE;
                r.kind   = cur_kind;
                r.number = number_t'(acc);
                r.eom    = 1'b1;
                return 1'b1;
            end
            P_PAYLOAD:
            begin
                remaining = remaining - 32'd1;
                if (remaining == '0)
                begin
                    phase = P_SKIP;
                    skip  = 2'd2;
                end
                r.kind     = cur_kind;
                r.payload  = b;
                r.has_byte = 1'b1;
                return 1'b1;
            end
            default:
            begin
                if (skip > 2'd1)
                begin
                    skip = skip - 2'd1;
                    return 1'b0;
                end
                skip   = '0;
                phase  = P_IDLE;
                r.kind = cur_kind;
                r.eom  = 1'b1;
                if (cur_kind != KIND_SIMPLE && cur_kind != KIND_ERROR)
                    r.number = number_t'(acc);
                return 1'b1;
            end
        endcase
    endfunction

    function automatic void check_field(input string name, input logic [63:0] want,
                                        input logic [63:0] got);
        if (got !== want)
        begin
            err_count++;
            $display("%0t: %s mismatch: expected %0h, actual %0h", $time, name, want, got);
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : watch
        reply_t seen;
        reply_t want;
        reply_t made;
        if (!rst_n)
        begin
            markers[CFG_SIMPLE_MARKER]  = RST_SIMPLE_MARKER;
            markers[CFG_ERROR_MARKER]   = RST_ERROR_MARKER;
            markers[CFG_INTEGER_MARKER] = RST_INTEGER_MARKER;
            markers[CFG_BULK_MARKER]    = RST_BULK_MARKER;
            markers[CFG_ARRAY_MARKER]   = RST_ARRAY_MARKER;
            markers[CFG_TERMINATOR]     = RST_TERMINATOR;
            phase     = P_IDLE;
            cur_kind  = KIND_SIMPLE;
            acc       = '0;
            minus     = 1'b0;
            remaining = '0;
            skip      = '0;
            expected_replies.delete();
            errors  <= err_count;
            pending <= 0;
        end
        else
        begin
            if (reply_stream.valid && reply_stream.ready)
            begin
                seen.kind     = reply_stream.msg_kind;
                seen.payload  = reply_stream.payload_byte;
                seen.has_byte = reply_stream.has_byte;
                seen.number   = reply_stream.number_value;
                seen.eom      = reply_stream.end_of_message;
                if (expected_replies.size() == 0)
                begin
                    err_count++;
                    $display("%0t: reply mismatch: expected none, actual kind %0d byte %h",
                             $time, seen.kind, seen.payload);
                    $display("    has_byte %b number %0h end_of_message %b",
                             seen.has_byte, seen.number, seen.eom);
                end
                else
                begin
                    want = expected_replies.pop_front();
                    check_field("msg_kind", 64'(want.kind), 64'(seen.kind));
                    check_field("payload_byte", 64'(want.payload), 64'(seen.payload));
                    check_field("has_byte", 64'(want.has_byte), 64'(seen.has_byte));
                    check_field("number_value", want.number, seen.number);
                    check_field("end_of_message", 64'(want.eom), 64'(seen.eom));
                end
            end
            // bytes taken at this edge still see the old register values
            if (byte_stream.valid && byte_stream.ready)
            begin
                if (parse_byte(byte_stream.in_byte, made))
                    expected_replies.push_back(made);
            end
            if (cfg_we && cfg_index <= CFG_TERMINATOR)
                markers[cfg_index] = cfg_data;
            errors  <= err_count;
            pending <= expected_replies.size();
        end
    end

endmodule

@@ bench/tb.sv @@
`timescale 1ns / 100ps

module tb;
    import rrsp_pkg::*;

    localparam int LEN_BITS      = LENGTH_BITS_DEF;
    localparam int NUM_REGS      = 6;
    localparam int PHASE_BYTES   = 400;
    localparam int HOLD_CYCLES   = 300;
    localparam int SETTLE_CYCLES = 4;
    localparam int STUCK_LIMIT   = 4000;

    localparam byte_t CH_CR = 8'h0D;
    localparam byte_t CH_LF = 8'h0A;

    logic     clk = 1'b0;
    logic     rst_n;
    logic     cfg_we;
    cfg_idx_t cfg_index;
    byte_t    cfg_data;

    rrsp_in_if  in_ch ();
    rrsp_out_if out_ch ();

    int errors;
    int pending;

    bit    quiet = 1'b0;
    int    holds_asked = 0;
    int    holds_served;
    int    phase_bytes;
    byte_t mark [0:5];
    byte_t setting [0:5];
    byte_t msg [$];

    always #5 clk = ~clk;

    resp_reply_stream_parser_core #(
        .LENGTH_BITS (LEN_BITS)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .bytes     (in_ch),
        .replies   (out_ch)
    );

    rrsp_reply_checker #(
        .LENGTH_BITS (LEN_BITS)
    ) replies_check (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .byte_stream  (in_ch),
        .reply_stream (out_ch),
        .errors       (errors),
        .pending      (pending)
    );

    function automatic bit is_digit(input byte_t b);
        return (b >= CH_ZERO) && (b <= CH_NINE);
    endfunction

    function automatic bit is_marker(input byte_t b);
        int i;
        for (i = 0; i <= int'(CFG_ARRAY_MARKER); i++)
            if (b == mark[i])
                return 1'b1;
        return 1'b0;
    endfunction

    function automatic byte_t rand_byte();
        return byte_t'($urandom_range(255));
    endfunction

    function automatic byte_t rand_digit();
        return CH_ZERO + byte_t'($urandom_range(9));
    endfunction

    function automatic byte_t rand_non_digit();
        byte_t b;
        do
            b = rand_byte();
        while (is_digit(b));
        return b;
    endfunction

    function automatic byte_t rand_content();
        byte_t b;
        do
            b = rand_byte();
        while (b == mark[CFG_TERMINATOR]);
        return b;
    endfunction

    function automatic byte_t length_delim();
        if (!is_digit(mark[CFG_TERMINATOR]) && $urandom_range(3) != 0)
            return mark[CFG_TERMINATOR];
        return rand_non_digit();
    endfunction

    function automatic void push_text(input string s);
        int i;
        for (i = 0; i < s.len(); i++)
            msg.push_back(byte_t'(s[i]));
    endfunction

    function automatic void push_line_end();
        msg.push_back(mark[CFG_TERMINATOR]);
        msg.push_back(CH_LF);
    endfunction

    // Mostly well-formed replies with random content, some broken ones and noise.
    function automatic void add_message();
        int    pick;
        int    n;
        pick = $urandom_range(99);
        if (pick < 25)
        begin
            msg.push_back(pick < 15 ? mark[CFG_SIMPLE_MARKER] : mark[CFG_ERROR_MARKER]);
            n = $urandom_range(8);
            repeat (n) msg.push_back(rand_content());
            push_line_end();
        end
        else if (pick < 45)
        begin
            msg.push_back(mark[CFG_INTEGER_MARKER]);
            if ($urandom_range(1) != 0)
                msg.push_back(CH_MINUS);
            n = $urandom_range(20);
            repeat (n) msg.push_back(rand_digit());
            if ($urandom_range(9) == 0)
            begin
                msg.push_back($urandom_range(1) != 0 ? CH_MINUS : rand_content());
                msg.push_back(rand_digit());
            end
            push_line_end();
        end
        else if (pick < 70)
        begin
            msg.push_back(mark[CFG_BULK_MARKER]);
            n = ($urandom_range(15) == 0) ? $urandom_range(40) : $urandom_range(8);
            push_text($sformatf("%0d", n));
            msg.push_back(length_delim());
            msg.push_back(CH_LF);
            repeat (n) msg.push_back(rand_byte());
            msg.push_back(CH_CR);
            msg.push_back(CH_LF);
        end
        else if (pick < 75)
        begin
            // null bulk: no digits before the delimiter
            msg.push_back(mark[CFG_BULK_MARKER]);
            push_text("-1\r\n");
        end
        else if (pick < 85)
        begin
            msg.push_back(mark[CFG_ARRAY_MARKER]);
            n = ($urandom_range(3) == 0) ? $urandom_range(14, 10) : $urandom_range(4, 1);
            repeat (n) msg.push_back(rand_digit());
            msg.push_back(length_delim());
            msg.push_back(CH_LF);
        end
        else if (pick < 90)
        begin
            byte_t b;
            do
                b = rand_byte();
            while (is_marker(b));
            msg.push_back(b);
        end
        else
        begin
            n = $urandom_range(6, 1);
            repeat (n) msg.push_back(rand_byte());
        end
    endfunction

    task automatic send_byte(input byte_t b);
        while (!quiet && $urandom_range(99) < 9)
        begin
            in_ch.valid <= 1'b0;
            @(posedge clk);
        end
        in_ch.valid   <= 1'b1;
        in_ch.in_byte <= b;
        @(posedge clk);
        while (!in_ch.ready) @(posedge clk);
        phase_bytes++;
    endtask

    task automatic send_msg();
        int i;
        for (i = 0; i < msg.size(); i++)
            send_byte(msg[i]);
        msg.delete();
    endtask

    task automatic run_random(input int count);
        phase_bytes = 0;
        while (phase_bytes < count)
        begin
            add_message();
            send_msg();
        end
    endtask

    // Stop offering bytes and wait out every outstanding reply.
    task automatic drain();
        in_ch.valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic program_regs();
        int i;
        for (i = 0; i < NUM_REGS; i++)
        begin
            cfg_we    <= 1'b1;
            cfg_index <= cfg_idx_t'(i);
            cfg_data  <= setting[i];
            mark[i]    = setting[i];
            @(posedge clk);
        end
        cfg_we <= 1'b0;
    endtask

    initial
    begin : receiver
        out_ch.ready <= 1'b0;
        holds_served = 0;
        forever
        begin
            @(posedge clk);
            if (holds_served != holds_asked)
            begin
                // hold off long enough for the parser to back up into its input
                out_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                holds_served++;
            end
            else
                out_ch.ready <= quiet || ($urandom_range(99) >= 9);
        end
    end

    initial
    begin : watchdog
        int stuck;
        stuck = 0;
        while (stuck < STUCK_LIMIT)
        begin
            @(posedge clk);
            if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
                stuck = 0;
            else
                stuck++;
        end
        $display("Mismatches found");
        $finish;
    end

    initial
    begin : stimulus
        int k;
        rst_n         <= 1'b0;
        cfg_we        <= 1'b0;
        cfg_index     <= CFG_SIMPLE_MARKER;
        cfg_data      <= '0;
        in_ch.valid   <= 1'b0;
        in_ch.in_byte <= '0;
        mark = '{RST_SIMPLE_MARKER, RST_ERROR_MARKER, RST_INTEGER_MARKER,
                 RST_BULK_MARKER, RST_ARRAY_MARKER, RST_TERMINATOR};
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: extreme content, signed integer, null bulk, saturating count,
        // unknown marker
        msg.push_back(mark[CFG_SIMPLE_MARKER]);
        msg.push_back(8'h00);
        msg.push_back(8'hFF);
        push_line_end();
        push_text(":-7\r\n");
        push_text("$-1\r\n");
        push_text("*9999999999\r\n");
        msg.push_back(8'hFF);
        send_msg();

        holds_asked <= holds_asked + 1;
        run_random(PHASE_BYTES);
        drain();

        // extreme register values, no idling on either side
        quiet <= 1'b1;
        setting = '{8'h00, 8'hFF, 8'h80, 8'h7F, 8'h01, 8'h00};
        program_regs();
        run_random(PHASE_BYTES);
        drain();
        quiet <= 1'b0;

        for (k = 0; k < NUM_REGS; k++)
            setting[k] = rand_byte();
        program_regs();
        run_random(PHASE_BYTES / 2);
        drain();
        run_random(PHASE_BYTES / 2);
        drain();

        // overlapping markers: the earlier one in priority order wins
        setting = '{RST_SIMPLE_MARKER, RST_SIMPLE_MARKER, RST_INTEGER_MARKER,
                    RST_INTEGER_MARKER, RST_ARRAY_MARKER, 8'hFF};
        program_regs();
        run_random(PHASE_BYTES);
        drain();

        setting = '{RST_SIMPLE_MARKER, RST_ERROR_MARKER, RST_INTEGER_MARKER,
                    RST_BULK_MARKER, RST_ARRAY_MARKER, RST_TERMINATOR};
        program_regs();
        run_random(PHASE_BYTES);
        drain();

        if (errors == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

@@ resp_reply_stream_parser_core.f @@
+incdir+hw/rtl
hw/rtl/rrsp_pkg.sv
hw/rtl/rrsp_if.sv
hw/rtl/resp_reply_stream_parser_core.sv
bench/rrsp_reply_checker.sv
bench/tb.sv
